### hdl/firc_pkg.sv
// Shared codes for the in-range coder: operating mode and result status.
// No dependencies; imported by the top level.
`default_nettype none

package firc_pkg;

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } t_mode;

    typedef enum logic {
        STATUS_OK    = 1'b0,
        STATUS_ERROR = 1'b1
    } t_status;

endpackage

`default_nettype wire

### hdl/firc_bounds.sv
// Range analysis: span d = H-L+1, k = floor(log2 d), 2^k, long-group size, short-code count.
// No package dependency; used by the in-range coder top level.
`default_nettype none

module firc_bounds #(
    parameter int VALUE_BITS = 8
) (
    input  wire logic [VALUE_BITS-1:0]         i_low_bound,
    input  wire logic [VALUE_BITS-1:0]         i_high_bound,
    output logic                               o_order_err,
    output logic [$clog2(VALUE_BITS+1)-1:0]    o_k,
    output logic [VALUE_BITS:0]                o_pow_k,
    output logic [VALUE_BITS:0]                o_half,
    output logic [VALUE_BITS:0]                o_short_cnt
);

    localparam int DW = VALUE_BITS + 1;
    localparam int KW = $clog2(VALUE_BITS + 1);

    logic [DW-1:0] span;
    logic [DW:0]   twice_pow;

    assign o_order_err = (i_low_bound > i_high_bound);
    assign span        = {1'b0, i_high_bound} - {1'b0, i_low_bound} + DW'(1);

    // leading-one position of the span
    always_comb begin
        o_k = '0;
        for (int i = 1; i < DW; i++) begin
            if (span[i]) begin
                o_k = KW'(i);
            end
        end
    end

    assign o_pow_k     = DW'(1) << o_k;
    assign twice_pow   = {o_pow_k, 1'b0};
    assign o_short_cnt = DW'(twice_pow - {1'b0, span});
    assign o_half      = span - o_pow_k;

endmodule

`default_nettype wire

### hdl/firc_encode.sv
// Encoder path: maps a value's offset to its in-range code and length.
// Takes range terms from firc_bounds; no package dependency.
`default_nettype none

module firc_encode #(
    parameter int VALUE_BITS = 8
) (
    input  wire logic [VALUE_BITS-1:0]         i_plain_value,
    input  wire logic [VALUE_BITS-1:0]         i_low_bound,
    input  wire logic [VALUE_BITS-1:0]         i_high_bound,
    input  wire logic [$clog2(VALUE_BITS+1)-1:0] i_k,
    input  wire logic [VALUE_BITS:0]           i_pow_k,
    input  wire logic [VALUE_BITS:0]           i_half,
    input  wire logic [VALUE_BITS:0]           i_short_cnt,
    output logic                               o_range_err,
    output logic [VALUE_BITS-1:0]              o_code_bits,
    output logic [$clog2(VALUE_BITS+1)-1:0]    o_code_length
);

    localparam int DW = VALUE_BITS + 1;
    localparam int LW = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] offset;
    logic [DW-1:0]         off_x;
    logic [DW-1:0]         mask;
    logic [DW-1:0]         code_x;

    assign o_range_err = (i_plain_value < i_low_bound) || (i_plain_value > i_high_bound);
    assign offset      = i_plain_value - i_low_bound;
    assign off_x       = {1'b0, offset};
    assign mask        = i_pow_k - DW'(1);

    // a + half == 2^k, so the upper long group starts at 2^k
    always_comb begin
        if (off_x < i_half) begin
            code_x        = off_x;
            o_code_length = i_k + LW'(1);
        end else if (off_x >= i_pow_k) begin
            code_x        = off_x - i_short_cnt;
            o_code_length = i_k + LW'(1);
        end else begin
            code_x        = ~(off_x - i_half) & mask;
            o_code_length = i_k;
        end
    end

    assign o_code_bits = code_x[VALUE_BITS-1:0];

endmodule

`default_nettype wire

### hdl/firc_decode.sv
// Decoder path: reads an MSB-first window, returns the value and bits consumed.
// Takes range terms from firc_bounds; no package dependency.
`default_nettype none

module firc_decode #(
    parameter int VALUE_BITS = 8
) (
    input  wire logic [VALUE_BITS-1:0]         i_code_window,
    input  wire logic [VALUE_BITS-1:0]         i_low_bound,
    input  wire logic [$clog2(VALUE_BITS+1)-1:0] i_k,
    input  wire logic [VALUE_BITS:0]           i_pow_k,
    input  wire logic [VALUE_BITS:0]           i_half,
    input  wire logic [VALUE_BITS:0]           i_short_cnt,
    output logic [VALUE_BITS-1:0]              o_decoded_value,
    output logic [$clog2(VALUE_BITS+1)-1:0]    o_code_length
);

    localparam int DW = VALUE_BITS + 1;
    localparam int KW = $clog2(VALUE_BITS + 1);
    localparam int LW = KW;

    logic [DW-1:0]         head;      // first k+1 window bits
    logic [VALUE_BITS-1:0] prefix;    // first k window bits
    logic [DW-1:0]         limit;
    logic [DW-1:0]         mask;
    logic [DW-1:0]         low_x;
    logic [DW-1:0]         dec_x;

    assign head   = {i_code_window, 1'b0} >> (KW'(VALUE_BITS) - i_k);
    assign prefix = i_code_window >> (KW'(VALUE_BITS) - i_k);
    assign limit  = {i_half[DW-2:0], 1'b0};
    assign mask   = i_pow_k - DW'(1);
    assign low_x  = {1'b0, i_low_bound};

    always_comb begin
        if (head < limit) begin
            o_code_length = i_k + LW'(1);
            if (head < i_half) begin
                dec_x = low_x + head;
            end else begin
                dec_x = low_x + head + i_short_cnt;
            end
        end else begin
            o_code_length = i_k;
            dec_x         = low_x + i_half + (~{1'b0, prefix} & mask);
        end
    end

    assign o_decoded_value = dec_x[VALUE_BITS-1:0];

endmodule

`default_nettype wire

### hdl/felics_in_range_code.sv
// Top level of the FELICS in-range (adjusted binary) coder: input register,
// range/encode/decode logic, result register. Uses firc_pkg, firc_bounds,
// firc_encode and firc_decode.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+---------------------------------------
//  item    | in        | start && !busy          | i_mode, i_low_bound, i_high_bound,
//          |           |                         | i_plain_value, i_code_window
//  result  | out       | o_strobe (one cycle)    | o_code_bits, o_code_length,
//          |           |                         | o_decoded_value, o_status
//
// One beat in per cycle while busy is low; each beat passes the input register,
// then the result register; throughput is one item per clock.
// busy is high only while in reset and until the first clock edge after it; otherwise
// the block always takes a beat. No state is carried between items.
// Synchronous active-low reset clears the valid flags; payload is not reset.
// The result side has no back-pressure: each result is shown for exactly one
// cycle and must be taken then.
`default_nettype none

module felics_in_range_code
    import firc_pkg::*;
#(
    parameter int VALUE_BITS = 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            i_mode,
    input  wire logic [VALUE_BITS-1:0]           i_low_bound,
    input  wire logic [VALUE_BITS-1:0]           i_high_bound,
    input  wire logic [VALUE_BITS-1:0]           i_plain_value,
    input  wire logic [VALUE_BITS-1:0]           i_code_window,
    output logic                                 o_strobe,
    output logic [VALUE_BITS-1:0]                o_code_bits,
    output logic [$clog2(VALUE_BITS+1)-1:0]      o_code_length,
    output logic [VALUE_BITS-1:0]                o_decoded_value,
    output logic                                 o_status
);

    localparam int KW = $clog2(VALUE_BITS + 1);
    localparam int DW = VALUE_BITS + 1;

    // ---- input register ----
    logic                  r_busy;
    logic                  r_in_valid;
    t_mode                 r_mode;
    logic [VALUE_BITS-1:0] r_low;
    logic [VALUE_BITS-1:0] r_high;
    logic [VALUE_BITS-1:0] r_value;
    logic [VALUE_BITS-1:0] r_window;

    logic accept;
    assign accept = start && !r_busy;
    assign busy   = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_in_valid <= 1'b0;
        end else begin
            r_busy     <= 1'b0;
            r_in_valid <= accept;
        end
        if (accept) begin
            r_mode   <= t_mode'(i_mode);
            r_low    <= i_low_bound;
            r_high   <= i_high_bound;
            r_value  <= i_plain_value;
            r_window <= i_code_window;
        end
    end

    // ---- range terms shared by both paths ----
    logic          order_err;
    logic [KW-1:0] k;
    logic [DW-1:0] pow_k;
    logic [DW-1:0] half;
    logic [DW-1:0] short_cnt;

    firc_bounds #(
        .VALUE_BITS (VALUE_BITS)
    ) u_bounds (
        .i_low_bound  (r_low),
        .i_high_bound (r_high),
        .o_order_err  (order_err),
        .o_k          (k),
        .o_pow_k      (pow_k),
        .o_half       (half),
        .o_short_cnt  (short_cnt)
    );

    // ---- encode path ----
    logic                  enc_range_err;
    logic [VALUE_BITS-1:0] enc_bits;
    logic [KW-1:0]         enc_len;

    firc_encode #(
        .VALUE_BITS (VALUE_BITS)
    ) u_encode (
        .i_plain_value (r_value),
        .i_low_bound   (r_low),
        .i_high_bound  (r_high),
        .i_k           (k),
        .i_pow_k       (pow_k),
        .i_half        (half),
        .i_short_cnt   (short_cnt),
        .o_range_err   (enc_range_err),
        .o_code_bits   (enc_bits),
        .o_code_length (enc_len)
    );

    // ---- decode path ----
    logic [VALUE_BITS-1:0] dec_value;
    logic [KW-1:0]         dec_len;

    firc_decode #(
        .VALUE_BITS (VALUE_BITS)
    ) u_decode (
        .i_code_window   (r_window),
        .i_low_bound     (r_low),
        .i_k             (k),
        .i_pow_k         (pow_k),
        .i_half          (half),
        .i_short_cnt     (short_cnt),
        .o_decoded_value (dec_value),
        .o_code_length   (dec_len)
    );

    // ---- result selection ----
    logic [VALUE_BITS-1:0] n_bits;
    logic [KW-1:0]         n_len;
    logic [VALUE_BITS-1:0] n_dec;
    t_status               n_status;

    always_comb begin
        n_bits   = '0;
        n_len    = '0;
        n_dec    = '0;
        n_status = STATUS_OK;
        if (order_err) begin
            n_status = STATUS_ERROR;
        end else begin
            unique case (r_mode)
                MODE_ENCODE: begin
                    if (enc_range_err) begin
                        n_status = STATUS_ERROR;
                    end else begin
                        n_bits = enc_bits;
                        n_len  = enc_len;
                    end
                end
                MODE_DECODE: begin
                    n_dec = dec_value;
                    n_len = dec_len;
                end
                default: begin
                    n_status = STATUS_ERROR;
                end
            endcase
        end
    end

    // ---- result register ----
    logic                  r_strobe;
    logic [VALUE_BITS-1:0] r_bits;
    logic [KW-1:0]         r_len;
    logic [VALUE_BITS-1:0] r_dec;
    t_status               r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_in_valid;
        end
        if (r_in_valid) begin
            r_bits   <= n_bits;
            r_len    <= n_len;
            r_dec    <= n_dec;
            r_status <= n_status;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_code_bits     = r_bits;
    assign o_code_length   = r_len;
    assign o_decoded_value = r_dec;
    assign o_status        = r_status;

`ifndef SYNTHESIS
    a_accept_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_strobe)
        else $error("accepted beat did not produce a result two cycles later");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |=> !o_strobe)
        else $error("result strobe without a registered item");

    a_error_clears_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == STATUS_ERROR) |->
            (o_code_bits == '0 && o_code_length == '0 && o_decoded_value == '0))
        else $error("error result carries non-zero fields");

    a_length_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_code_length <= KW'(VALUE_BITS)))
        else $error("code length exceeds value width");

    a_one_path_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_decoded_value != '0) |-> (o_code_bits == '0))
        else $error("encode and decode fields both populated");
`endif

endmodule

`default_nettype wire
